>>> design/rob_pkg.sv
// shared types and constants for the in-order release reorder buffer
`timescale 1ns / 1ps

package rob_pkg;

    // slot count; a power of two so that a sequence number picks its slot by its low bits
    localparam int unsigned WINDOW      = 32;
    localparam int unsigned SLOT_W      = $clog2(WINDOW);
    localparam int unsigned MAX_RESULTS = 32;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int unsigned SEQ_W       = 32;
    localparam int unsigned PAY_W       = 32;

    typedef enum logic [1:0] {
        KIND_RELEASE = 2'd0,
        KIND_STALE   = 2'd1,
        KIND_BEYOND  = 2'd2,
        KIND_DUP     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_CLASSIFY = 2'd1,
        ST_DRAIN    = 2'd2,
        ST_EMIT     = 2'd3
    } state_t;

    typedef struct packed {
        logic [SEQ_W-1:0] item_sequence;
        logic [PAY_W-1:0] item_payload;
    } item_t;

    typedef struct packed {
        kind_t            result_kind;
        logic [SEQ_W-1:0] out_sequence;
        logic [PAY_W-1:0] out_payload;
        logic [SEQ_W-1:0] expected_after;
        logic             last_of_run;
    } result_t;

    typedef struct packed {
        logic capture;
        logic store;
        logic drop_emit;
        logic read;
        logic release_emit;
    } cmd_t;

    typedef struct packed {
        logic is_drop;
        logic head_ready;
        logic out_free;
    } status_t;

endpackage

>>> design/rob_ctrl.sv
// controller state machine for the reorder buffer
`timescale 1ns / 1ps

module rob_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  rob_pkg::status_t  status,
    output rob_pkg::cmd_t     cmd
);

    rob_pkg::state_t state_reg;
    rob_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rob_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            rob_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = rob_pkg::ST_CLASSIFY;
                end
            end
            rob_pkg::ST_CLASSIFY:
            begin
                if (!status.is_drop)
                begin
                    cmd.store  = 1'b1;
                    state_next = rob_pkg::ST_DRAIN;
                end
                else if (status.out_free)
                begin
                    cmd.drop_emit = 1'b1;
                    state_next    = rob_pkg::ST_DRAIN;
                end
            end
            rob_pkg::ST_DRAIN:
            begin
                if (status.head_ready)
                begin
                    cmd.read   = 1'b1;
                    state_next = rob_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = rob_pkg::ST_IDLE;
                end
            end
            rob_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.release_emit = 1'b1;
                    state_next       = rob_pkg::ST_DRAIN;
                end
            end
            default:
            begin
                state_next = rob_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/rob_dp.sv
// datapath: expected counter, slot store, valid bits and result register
`timescale 1ns / 1ps

module rob_dp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rob_pkg::item_t              item,
    input  logic                        cfg_we,
    input  logic [rob_pkg::SEQ_W-1:0]   cfg_data,
    input  rob_pkg::cmd_t               cmd,
    output rob_pkg::status_t            status,
    output logic                        result_valid,
    input  logic                        result_stall,
    output rob_pkg::result_t            result
);

    logic [rob_pkg::SEQ_W-1:0]  seq_reg;
    logic [rob_pkg::PAY_W-1:0]  pay_reg;
    logic [rob_pkg::PAY_W-1:0]  rd_data_reg;
    logic [rob_pkg::PAY_W-1:0]  payload_mem [rob_pkg::WINDOW];
    logic [rob_pkg::SEQ_W-1:0]  exp_reg;
    logic [rob_pkg::SEQ_W-1:0]  exp_next;
    logic [rob_pkg::WINDOW-1:0] valid_reg;
    logic [rob_pkg::WINDOW-1:0] valid_next;
    logic [rob_pkg::CNT_W-1:0]  cnt_reg;
    logic [rob_pkg::CNT_W-1:0]  cnt_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    rob_pkg::result_t           out_reg;
    rob_pkg::result_t           out_next;

    logic [rob_pkg::SLOT_W-1:0] seq_slot;
    logic [rob_pkg::SLOT_W-1:0] head_slot;
    logic [rob_pkg::SLOT_W-1:0] next_slot;
    logic [rob_pkg::SEQ_W-1:0]  diff;
    logic [rob_pkg::SEQ_W-1:0]  exp_inc;
    logic [rob_pkg::CNT_W-1:0]  cnt_inc;
    logic                       is_stale;
    logic                       is_beyond;
    logic                       is_dup;
    logic                       head_valid;
    logic                       next_valid;
    logic                       cnt_full;
    rob_pkg::kind_t             drop_kind;

    assign seq_slot   = seq_reg[rob_pkg::SLOT_W-1:0];
    assign head_slot  = exp_reg[rob_pkg::SLOT_W-1:0];
    assign next_slot  = head_slot + rob_pkg::SLOT_W'(1);
    assign diff       = seq_reg - exp_reg;
    assign exp_inc    = exp_reg + rob_pkg::SEQ_W'(1);
    assign cnt_inc    = cnt_reg + rob_pkg::CNT_W'(1);
    assign is_stale   = seq_reg < exp_reg;
    assign is_beyond  = diff >= rob_pkg::SEQ_W'(rob_pkg::WINDOW);
    assign is_dup     = valid_reg[seq_slot];
    assign head_valid = valid_reg[head_slot];
    assign next_valid = valid_reg[next_slot];
    assign cnt_full   = cnt_reg == rob_pkg::CNT_W'(rob_pkg::MAX_RESULTS);

    always_comb
    begin
        if (is_stale)
        begin
            drop_kind = rob_pkg::KIND_STALE;
        end
        else if (is_beyond)
        begin
            drop_kind = rob_pkg::KIND_BEYOND;
        end
        else
        begin
            drop_kind = rob_pkg::KIND_DUP;
        end
    end

    assign status.is_drop    = is_stale || is_beyond || is_dup;
    assign status.head_ready = head_valid && !cnt_full;
    assign status.out_free   = !out_valid_reg || !result_stall;

    always_comb
    begin
        exp_next       = exp_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (cmd.capture)
        begin
            cnt_next = '0;
        end
        if (cmd.store)
        begin
            valid_next[seq_slot] = 1'b1;
        end
        if (cmd.drop_emit)
        begin
            out_next.result_kind    = drop_kind;
            out_next.out_sequence   = seq_reg;
            out_next.out_payload    = pay_reg;
            out_next.expected_after = exp_reg;
            out_next.last_of_run    = !head_valid;
            out_valid_next          = 1'b1;
            cnt_next                = cnt_inc;
        end
        if (cmd.release_emit)
        begin
            out_next.result_kind    = rob_pkg::KIND_RELEASE;
            out_next.out_sequence   = exp_reg;
            out_next.out_payload    = rd_data_reg;
            out_next.expected_after = exp_inc;
            out_next.last_of_run    = !next_valid
                                      || (cnt_inc == rob_pkg::CNT_W'(rob_pkg::MAX_RESULTS));
            out_valid_next          = 1'b1;
            valid_next[head_slot]   = 1'b0;
            exp_next                = exp_inc;
            cnt_next                = cnt_inc;
        end
        if (cfg_we)
        begin
            exp_next   = cfg_data;
            valid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg       <= rob_pkg::SEQ_W'(1);
            valid_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            exp_reg       <= exp_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (cmd.capture)
        begin
            seq_reg <= item.item_sequence;
            pay_reg <= item.item_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            payload_mem[seq_slot] <= pay_reg;
        end
        if (cmd.read)
        begin
            rd_data_reg <= payload_mem[head_slot];
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

>>> design/in_order_release_reorder_buffer.sv
// top level of the in-order release reorder buffer
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// item      in         item_valid / item_stall   rob_pkg::item_t
// result    out        result_valid / result_stall rob_pkg::result_t
// cfg       in         cfg_we                    cfg_data (start sequence)
//
// an item steps through accept, classify and store, and head check; each release adds a
// read and an emit step; releases go through the slot memory, one registered read per release
// the result register lets an item be taken while the last result still waits
// reset loads the expected number with 1 and clears every slot valid bit
// a stalled result holds the controller in its classify step for a drop
// and in its emit step for a release

module in_order_release_reorder_buffer
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  rob_pkg::item_t            item,
    output logic                      result_valid,
    input  logic                      result_stall,
    output rob_pkg::result_t          result,
    input  logic                      cfg_we,
    input  logic [rob_pkg::SEQ_W-1:0] cfg_data
);

    rob_pkg::cmd_t    cmd;
    rob_pkg::status_t status;

    rob_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    rob_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // busy after each accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("item taken while previous one in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.result_kind == rob_pkg::KIND_RELEASE)
        |-> (result.expected_after == result.out_sequence + rob_pkg::SEQ_W'(1)))
        else $error("release does not advance expected number");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.result_kind == rob_pkg::KIND_STALE)
        |-> (result.out_sequence < result.expected_after))
        else $error("stale drop not below expected number");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.result_kind == rob_pkg::KIND_BEYOND)
        |-> ((result.out_sequence - result.expected_after)
             >= rob_pkg::SEQ_W'(rob_pkg::WINDOW)))
        else $error("window drop inside window");

endmodule

>>> tb/in_order_release_reorder_buffer_test.sv
// self-checking testbench for the in-order release reorder buffer
`timescale 1ns / 1ps

module in_order_release_reorder_buffer_test;

    import rob_pkg::*;

    localparam int ITEMS      = 280;
    localparam int SETTLE     = 24;
    localparam int IDLE_LIMIT = 4000;
    localparam int IDLE_PCT   = 22;

    class rob_scoreboard;
        logic [SEQ_W-1:0] next_seq;
        logic [PAY_W-1:0] slot_pay [WINDOW];
        bit               slot_full [WINDOW];
        result_t          awaited [$];
        int               errors;

        function new();
            errors = 0;
            foreach (slot_pay[i])
                slot_pay[i] = '0;
            restart(1);
        endfunction

        function void restart(logic [SEQ_W-1:0] start);
            next_seq = start;
            foreach (slot_full[i])
                slot_full[i] = 1'b0;
        endfunction

        function int backlog();
            return awaited.size();
        endfunction

        function void push_result(kind_t kind, logic [SEQ_W-1:0] seq,
                                  logic [PAY_W-1:0] pay);
            result_t r;
            r.result_kind    = kind;
            r.out_sequence   = seq;
            r.out_payload    = pay;
            r.expected_after = next_seq;
            r.last_of_run    = 1'b0;
            awaited.push_back(r);
        endfunction

        // accepted item: classify, store, then release the consecutive run from the head
        function void note_item(item_t beat);
            logic [SEQ_W-1:0]  gap;
            logic [SLOT_W-1:0] slot;
            logic [SLOT_W-1:0] head;
            logic [SEQ_W-1:0]  rel_seq;
            result_t           r;
            int                n;
            n    = 0;
            gap  = beat.item_sequence - next_seq;
            slot = beat.item_sequence[SLOT_W-1:0];
            if (beat.item_sequence < next_seq)
            begin
                push_result(KIND_STALE, beat.item_sequence, beat.item_payload);
                n++;
            end
            else if (gap >= WINDOW)
            begin
                push_result(KIND_BEYOND, beat.item_sequence, beat.item_payload);
                n++;
            end
            else if (slot_full[slot])
            begin
                push_result(KIND_DUP, beat.item_sequence, beat.item_payload);
                n++;
            end
            else
            begin
                slot_full[slot] = 1'b1;
                slot_pay[slot]  = beat.item_payload;
            end
            while (n < MAX_RESULTS)
            begin
                head = next_seq[SLOT_W-1:0];
                if (!slot_full[head])
                    break;
                slot_full[head] = 1'b0;
                rel_seq  = next_seq;
                next_seq = next_seq + 1;
                push_result(KIND_RELEASE, rel_seq, slot_pay[head]);
                n++;
            end
            if (n > 0)
            begin
                r = awaited.pop_back();
                r.last_of_run = 1'b1;
                awaited.push_back(r);
            end
        endfunction

        function void report(string field, logic [SEQ_W-1:0] want, logic [SEQ_W-1:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t mismatch %s expected %h actual %h", $time, field, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result expected none actual %h", $time, got);
                return;
            end
            want = awaited.pop_front();
            report("result_kind", SEQ_W'(want.result_kind), SEQ_W'(got.result_kind));
            report("out_sequence", want.out_sequence, got.out_sequence);
            report("out_payload", want.out_payload, got.out_payload);
            report("expected_after", want.expected_after, got.expected_after);
            report("last_of_run", SEQ_W'(want.last_of_run), SEQ_W'(got.last_of_run));
        endfunction
    endclass

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    item_t            item_bus     = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    result_t          result_bus;
    logic             cfg_we       = 1'b0;
    logic [SEQ_W-1:0] cfg_data     = '0;

    rob_scoreboard sb = new();
    int            items_sent = 0;
    int            quiet_cycles = 0;
    bit            steady = 1'b0;

    in_order_release_reorder_buffer dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_bus),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: check the accepted beat, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_bus);
        result_stall <= rst_n && !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [SEQ_W-1:0] seq, input logic [PAY_W-1:0] pay);
        item_t beat;
        beat.item_sequence = seq;
        beat.item_payload  = pay;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_bus   <= beat;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(beat);
        items_sent++;
    endtask

    // drain everything, let the controller settle, then load a new start number
    task automatic load_start(input logic [SEQ_W-1:0] start);
        item_valid <= 1'b0;
        while (sb.backlog() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= start;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.restart(start);
    endtask

    initial
    begin
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] noise;
        int               offs [WINDOW];
        int               n;
        int               j;
        int               tmp;
        int               phase;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // head release, stale, beyond, hold without release, duplicate, run release
        send_item(32'd1, 32'h0000_0000);
        send_item(32'd0, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'h0000_0000);
        send_item(32'd3, 32'hA5A5_A5A5);
        send_item(32'd3, 32'h5A5A_5A5A);
        send_item(32'd2, 32'h0000_FFFF);
        send_item(32'd36, 32'h0000_0001);
        send_item(32'd35, 32'h0000_0002);
        send_item(32'd4, 32'h0000_0003);

        // expected counter wrapping through zero
        load_start(32'hFFFF_FFFC);
        send_item(32'd1, 32'h1111_1111);
        send_item(32'd0, 32'h2222_2222);
        send_item(32'hFFFF_FFFF, 32'h3333_3333);
        send_item(32'hFFFF_FFFD, 32'h4444_4444);
        send_item(32'hFFFF_FFFE, 32'h5555_5555);
        send_item(32'hFFFF_FFFC, 32'h6666_6666);
        send_item(32'hFFFF_FFFD, 32'h7777_7777);
        send_item(32'd2, 32'h8888_8888);

        load_start(32'd0);
        send_item(32'd0, 32'h9999_9999);

        load_start(32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'hCCCC_CCCC);
        send_item(32'hFFFF_FFFE, 32'hDDDD_DDDD);

        load_start(32'd1);

        phase = 0;
        while (items_sent < ITEMS)
        begin
            if (phase % 4 == 3)
            begin
                case ($urandom_range(0, 3))
                    0: load_start($urandom);
                    1: load_start(32'hFFFF_FFFF - $urandom_range(0, 40));
                    2: load_start($urandom_range(0, 40));
                    default: load_start(32'd1);
                endcase
            end
            base = sb.next_seq;
            n = ($urandom_range(0, 9) == 0) ? WINDOW : $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                offs[i] = i;
            for (int i = n - 1; i > 0; i--)
            begin
                j       = $urandom_range(0, i);
                tmp     = offs[i];
                offs[i] = offs[j];
                offs[j] = tmp;
            end
            // a full window keeps the head for last so the whole run comes out at once
            if (n == WINDOW)
            begin
                for (int i = 0; i < n; i++)
                    if (offs[i] == 0)
                        j = i;
                offs[j]     = offs[n - 1];
                offs[n - 1] = 0;
            end
            for (int i = 0; i < n; i++)
            begin
                steady = (items_sent >= 110) && (items_sent < 170);
                if ($urandom_range(0, 99) < 15)
                begin
                    case ($urandom_range(0, 3))
                        0: noise = base - 1 - $urandom_range(0, 100);
                        1: noise = (i > 0) ? base + offs[$urandom_range(0, i - 1)] : base - 1;
                        2: noise = base + WINDOW + $urandom_range(0, 1000);
                        default: noise = $urandom;
                    endcase
                    send_item(noise, $urandom);
                end
                send_item(base + offs[i], $urandom);
            end
            phase++;
        end
        steady = 1'b0;

        item_valid <= 1'b0;
        while (sb.backlog() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
design/rob_pkg.sv
design/rob_ctrl.sv
design/rob_dp.sv
design/in_order_release_reorder_buffer.sv
tb/in_order_release_reorder_buffer_test.sv
